// ===== src/ccl_pkg.sv =====
package ccl_pkg;

  localparam int MaxRowsDef    = 64;
  localparam int MaxColsDef    = 64;
  localparam int LabelDepthDef = 1024;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_RDL  = 2'd2;
  localparam logic [1:0] REQ_RDP  = 2'd3;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_IDX = 2'd2;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_CLR,
    ST_P_CUR,
    ST_P_CHK,
    ST_NB_RD,
    ST_NB_WT,
    ST_F_DEC,
    ST_F_EQ,
    ST_B_DEC,
    ST_B_EQR,
    ST_B_EQD,
    ST_P_NEXT,
    ST_FL_RD,
    ST_FL_WT,
    ST_FL_RD2,
    ST_Z_EQD,
    ST_Z_PRD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PASS_FWD,
    PASS_BWD,
    PASS_FIN
  } pass_e;

  typedef struct packed {
    logic [1:0] req;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] pix;
    logic [9:0] comp;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  label_or_count;
    logic [12:0] num_pixels;
    logic [6:0]  min_row;
    logic [6:0]  min_col;
    logic [6:0]  max_row;
    logic [6:0]  max_col;
  } res_t;

endpackage

// ===== src/ccl_ram.sv =====
module ccl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/ccl_core.sv =====
module ccl_core #(
  parameter int MAX_ROWS    = ccl_pkg::MaxRowsDef,
  parameter int MAX_COLS    = ccl_pkg::MaxColsDef,
  parameter int LABEL_DEPTH = ccl_pkg::LabelDepthDef,
  localparam int NRW = $clog2(MAX_ROWS + 1),
  localparam int NCW = $clog2(MAX_COLS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NRW-1:0] nrows_i,
  input  logic [NCW-1:0] ncols_i,
  input  logic          cmd_vld_i,
  output logic          cmd_rdy_o,
  input  ccl_pkg::cmd_t cmd_i,
  output logic          res_vld_o,
  input  logic          res_rdy_i,
  output ccl_pkg::res_t res_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int PIX   = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(PIX);
  localparam int LW    = $clog2(LABEL_DEPTH);
  localparam int PCW   = $clog2(PIX + 1);
  localparam int O_RMAX = NCW;
  localparam int O_CMIN = NCW + NRW;
  localparam int O_RMIN = 2 * NCW + NRW;
  localparam int O_CNT  = 2 * NCW + 2 * NRW;
  localparam int PW     = O_CNT + PCW;

  ccl_pkg::state_e state_q, state_d;
  ccl_pkg::pass_e  pass_q, pass_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [1:0]    k_q, k_d;
  logic [LW-1:0] cur_q, cur_d, lab_q, lab_d, i_q, i_d;
  logic [LW-1:0] next_label_q, next_label_d, count_q, count_d;
  logic          ovf_q, ovf_d, inb_q, inb_d;
  logic [LW-1:0] nb_q [4];
  logic [LW-1:0] nb_d [4];
  logic [1:0]    req_q, req_d;
  logic          rd_ok_q, rd_ok_d;
  logic          out_vld_q, out_vld_d;
  ccl_pkg::res_t out_q, out_d;

  logic          img_we, eq_we, pr_we;
  logic [AW-1:0] img_wa, img_ra;
  logic [LW-1:0] img_wd, img_rd, eq_wa, eq_wd, eq_ra, eq_rd, pr_wa, pr_ra;
  logic [PW-1:0] pr_wd, pr_rd;

  ccl_ram #(.W(LW), .D(PIX)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_wa), .wdata_i(img_wd),
    .raddr_i(img_ra), .rdata_o(img_rd)
  );
  ccl_ram #(.W(LW), .D(LABEL_DEPTH)) u_eq (
    .clk_i, .we_i(eq_we), .waddr_i(eq_wa), .wdata_i(eq_wd),
    .raddr_i(eq_ra), .rdata_o(eq_rd)
  );
  ccl_ram #(.W(PW), .D(LABEL_DEPTH)) u_prop (
    .clk_i, .we_i(pr_we), .waddr_i(pr_wa), .wdata_i(pr_wd),
    .raddr_i(pr_ra), .rdata_o(pr_rd)
  );

  function automatic logic [AW-1:0] img_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    img_addr = AW'(r * MAX_COLS) + AW'(c);
  endfunction

  // Request decode.
  logic          pos_ok;
  logic [RW-1:0] req_r;
  logic [CW-1:0] req_c;
  logic          comp_ok;
  assign pos_ok = (cmd_i.row != 7'd0) && (cmd_i.col != 7'd0) &&
                  (32'(cmd_i.row) <= 32'(nrows_i)) && (32'(cmd_i.col) <= 32'(ncols_i));
  assign req_r  = RW'(cmd_i.row - 7'd1);
  assign req_c  = CW'(cmd_i.col - 7'd1);
  assign comp_ok = (cmd_i.comp != 10'd0) && (32'(cmd_i.comp) <= 32'(count_q)) &&
                   (32'(cmd_i.comp) < LABEL_DEPTH);
  assign cmd_rdy_o = (state_q == ccl_pkg::ST_IDLE) && (!out_vld_q || res_rdy_i);

  // Scan position helpers.
  logic          r_last, c_last, rm_ok, rp_ok, cm_ok, cp_ok, scan_end;
  logic [RW-1:0] rm1, rp1;
  logic [CW-1:0] cm1, cp1;
  assign rm1   = r_q - 1'b1;
  assign rp1   = r_q + 1'b1;
  assign cm1   = c_q - 1'b1;
  assign cp1   = c_q + 1'b1;
  assign rm_ok = (r_q != '0);
  assign cm_ok = (c_q != '0);
  assign rp_ok = (NRW'(r_q) + NRW'(1)) < nrows_i;
  assign cp_ok = (NCW'(c_q) + NCW'(1)) < ncols_i;
  assign r_last = !rp_ok;
  assign c_last = !cp_ok;
  assign scan_end = (pass_q == ccl_pkg::PASS_BWD) ? (!rm_ok && !cm_ok) : (r_last && c_last);

  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic          nin;
  always_comb begin
    nr = r_q;
    nc = c_q;
    nin = 1'b0;
    case ({pass_q == ccl_pkg::PASS_BWD, k_q})
      3'b000: begin nr = rm1; nc = cm1; nin = rm_ok && cm_ok; end
      3'b001: begin nr = rm1; nc = c_q; nin = rm_ok; end
      3'b010: begin nr = rm1; nc = cp1; nin = rm_ok && cp_ok; end
      3'b011: begin nr = r_q; nc = cm1; nin = cm_ok; end
      3'b100: begin nr = r_q; nc = cp1; nin = cp_ok; end
      3'b101: begin nr = rp1; nc = c_q; nin = rp_ok; end
      3'b110: begin nr = rp1; nc = cp1; nin = rp_ok && cp_ok; end
      3'b111: begin nr = rp1; nc = cm1; nin = rp_ok && cm_ok; end
      default: begin nr = r_q; nc = c_q; nin = 1'b0; end
    endcase
  end

  // Shared compare unit over the four neighbour labels.
  logic [LW-1:0] fbest, bbest;
  logic          bdiff;
  always_comb begin
    fbest = '0;
    bbest = cur_q;
    bdiff = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (nb_q[k] != '0 && (fbest == '0 || nb_q[k] < fbest)) fbest = nb_q[k];
      if (nb_q[k] != '0 && nb_q[k] != cur_q) begin
        if (nb_q[k] < bbest) bbest = nb_q[k];
        bdiff = 1'b1;
      end
    end
  end

  // Property update from the current scan position.
  logic [NRW-1:0] rr;
  logic [NCW-1:0] cc;
  logic [PW-1:0]  pr_upd;
  assign rr = NRW'(r_q) + NRW'(1);
  assign cc = NCW'(c_q) + NCW'(1);
  always_comb begin
    pr_upd = pr_rd;
    if (pr_rd[O_CNT +: PCW] == '0) begin
      pr_upd[O_RMIN +: NRW] = rr;
      pr_upd[O_RMAX +: NRW] = rr;
      pr_upd[O_CMIN +: NCW] = cc;
      pr_upd[0 +: NCW]      = cc;
    end else begin
      if (rr < pr_rd[O_RMIN +: NRW]) pr_upd[O_RMIN +: NRW] = rr;
      if (rr > pr_rd[O_RMAX +: NRW]) pr_upd[O_RMAX +: NRW] = rr;
      if (cc < pr_rd[O_CMIN +: NCW]) pr_upd[O_CMIN +: NCW] = cc;
      if (cc > pr_rd[0 +: NCW])      pr_upd[0 +: NCW]      = cc;
    end
    pr_upd[O_CNT +: PCW] = pr_rd[O_CNT +: PCW] + 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccl_pkg::ST_IDLE: begin
        if (cmd_vld_i && cmd_rdy_o) begin
          case (cmd_i.req)
            ccl_pkg::REQ_RUN:  state_d = ccl_pkg::ST_CLR;
            ccl_pkg::REQ_RDL:  state_d = ccl_pkg::ST_RD_WAIT;
            ccl_pkg::REQ_RDP:  state_d = ccl_pkg::ST_RD_WAIT;
            default:           state_d = ccl_pkg::ST_IDLE;
          endcase
        end
      end
      ccl_pkg::ST_RD_WAIT: state_d = ccl_pkg::ST_IDLE;
      ccl_pkg::ST_CLR: begin
        if (32'(i_q) == LABEL_DEPTH - 1) state_d = ccl_pkg::ST_P_CUR;
      end
      ccl_pkg::ST_P_CUR: state_d = ccl_pkg::ST_P_CHK;
      ccl_pkg::ST_P_CHK: begin
        if (img_rd == '0) state_d = ccl_pkg::ST_P_NEXT;
        else if (pass_q == ccl_pkg::PASS_FIN) state_d = ccl_pkg::ST_Z_EQD;
        else state_d = ccl_pkg::ST_NB_RD;
      end
      ccl_pkg::ST_NB_RD: state_d = ccl_pkg::ST_NB_WT;
      ccl_pkg::ST_NB_WT: begin
        if (k_q != 2'd3) state_d = ccl_pkg::ST_NB_RD;
        else if (pass_q == ccl_pkg::PASS_FWD) state_d = ccl_pkg::ST_F_DEC;
        else state_d = ccl_pkg::ST_B_DEC;
      end
      ccl_pkg::ST_F_DEC: state_d = (fbest != '0) ? ccl_pkg::ST_F_EQ : ccl_pkg::ST_P_NEXT;
      ccl_pkg::ST_F_EQ: begin
        if (k_q == 2'd3) state_d = ccl_pkg::ST_P_NEXT;
      end
      ccl_pkg::ST_B_DEC: state_d = ccl_pkg::ST_B_EQR;
      ccl_pkg::ST_B_EQR: state_d = ccl_pkg::ST_B_EQD;
      ccl_pkg::ST_B_EQD: state_d = ccl_pkg::ST_P_NEXT;
      ccl_pkg::ST_P_NEXT: begin
        if (!scan_end) state_d = ccl_pkg::ST_P_CUR;
        else begin
          case (pass_q)
            ccl_pkg::PASS_FWD: state_d = ccl_pkg::ST_P_CUR;
            ccl_pkg::PASS_BWD: state_d = (next_label_q == '0) ? ccl_pkg::ST_P_CUR
                                                              : ccl_pkg::ST_FL_RD;
            default:           state_d = ccl_pkg::ST_DONE;
          endcase
        end
      end
      ccl_pkg::ST_FL_RD: state_d = ccl_pkg::ST_FL_WT;
      ccl_pkg::ST_FL_WT: begin
        if (eq_rd != i_q) state_d = ccl_pkg::ST_FL_RD2;
        else if (i_q == next_label_q) state_d = ccl_pkg::ST_P_CUR;
        else state_d = ccl_pkg::ST_FL_RD;
      end
      ccl_pkg::ST_FL_RD2: begin
        state_d = (i_q == next_label_q) ? ccl_pkg::ST_P_CUR : ccl_pkg::ST_FL_RD;
      end
      ccl_pkg::ST_Z_EQD: state_d = (eq_rd == '0) ? ccl_pkg::ST_P_NEXT : ccl_pkg::ST_Z_PRD;
      ccl_pkg::ST_Z_PRD: state_d = ccl_pkg::ST_P_NEXT;
      ccl_pkg::ST_DONE: state_d = ccl_pkg::ST_IDLE;
      default: state_d = ccl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pass_d = pass_q;
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    cur_d = cur_q;
    lab_d = lab_q;
    i_d = i_q;
    next_label_d = next_label_q;
    count_d = count_q;
    ovf_d = ovf_q;
    inb_d = inb_q;
    nb_d = nb_q;
    req_d = req_q;
    rd_ok_d = rd_ok_q;
    out_d = out_q;
    out_vld_d = out_vld_q && !res_rdy_i;
    img_we = 1'b0; img_wa = img_addr(r_q, c_q); img_wd = '0; img_ra = img_addr(r_q, c_q);
    eq_we = 1'b0; eq_wa = '0; eq_wd = '0; eq_ra = '0;
    pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_ra = '0;

    case (state_q)
      ccl_pkg::ST_IDLE: begin
        img_ra = img_addr(req_r, req_c);
        pr_ra  = LW'(cmd_i.comp);
        if (cmd_vld_i && cmd_rdy_o) begin
          req_d = cmd_i.req;
          out_d = '0;
          case (cmd_i.req)
            ccl_pkg::REQ_LOAD: begin
              out_vld_d = 1'b1;
              if (pos_ok) begin
                img_we = 1'b1;
                img_wa = img_addr(req_r, req_c);
                img_wd = (cmd_i.pix != 8'd0) ? LW'(1) : '0;
              end else begin
                out_d.status = ccl_pkg::STAT_IDX;
              end
            end
            ccl_pkg::REQ_RUN: begin
              next_label_d = '0;
              ovf_d = 1'b0;
              i_d = '0;
            end
            ccl_pkg::REQ_RDL: rd_ok_d = pos_ok;
            default:          rd_ok_d = comp_ok;
          endcase
        end
      end
      ccl_pkg::ST_RD_WAIT: begin
        out_vld_d = 1'b1;
        out_d = '0;
        if (!rd_ok_q) begin
          out_d.status = ccl_pkg::STAT_IDX;
        end else if (req_q == ccl_pkg::REQ_RDL) begin
          out_d.label_or_count = 10'(img_rd);
        end else begin
          out_d.num_pixels = 13'(pr_rd[O_CNT +: PCW]);
          out_d.min_row    = 7'(pr_rd[O_RMIN +: NRW]);
          out_d.min_col    = 7'(pr_rd[O_CMIN +: NCW]);
          out_d.max_row    = 7'(pr_rd[O_RMAX +: NRW]);
          out_d.max_col    = 7'(pr_rd[0 +: NCW]);
        end
      end
      ccl_pkg::ST_CLR: begin
        pr_we = 1'b1;
        pr_wa = i_q;
        i_d = i_q + 1'b1;
        pass_d = ccl_pkg::PASS_FWD;
        r_d = '0;
        c_d = '0;
      end
      ccl_pkg::ST_P_CHK: begin
        cur_d = img_rd;
        k_d = '0;
        eq_ra = img_rd;
      end
      ccl_pkg::ST_NB_RD: begin
        img_ra = img_addr(nr, nc);
        inb_d = nin;
      end
      ccl_pkg::ST_NB_WT: begin
        nb_d[k_q] = inb_q ? img_rd : '0;
        k_d = k_q + 1'b1;
      end
      ccl_pkg::ST_F_DEC: begin
        img_we = 1'b1;
        k_d = '0;
        if (fbest != '0) begin
          img_wd = fbest;
        end else if (32'(next_label_q) >= LABEL_DEPTH - 1) begin
          ovf_d = 1'b1;
        end else begin
          next_label_d = next_label_q + 1'b1;
          img_wd = next_label_q + 1'b1;
          eq_we = 1'b1;
          eq_wa = next_label_q + 1'b1;
          eq_wd = next_label_q + 1'b1;
        end
      end
      ccl_pkg::ST_F_EQ: begin
        k_d = k_q + 1'b1;
        if (nb_q[k_q] > fbest) begin
          eq_we = 1'b1;
          eq_wa = nb_q[k_q];
          eq_wd = fbest;
        end
      end
      ccl_pkg::ST_B_DEC: begin
        if (bdiff && cur_q > bbest) begin
          eq_we = 1'b1;
          eq_wa = cur_q;
          eq_wd = bbest;
          cur_d = bbest;
        end
      end
      ccl_pkg::ST_B_EQR: eq_ra = cur_q;
      ccl_pkg::ST_B_EQD: begin
        img_we = 1'b1;
        img_wd = eq_rd;
      end
      ccl_pkg::ST_P_NEXT: begin
        if (!scan_end) begin
          if (pass_q == ccl_pkg::PASS_BWD) begin
            if (!cm_ok) begin
              c_d = CW'(ncols_i - NCW'(1));
              r_d = rm1;
            end else begin
              c_d = cm1;
            end
          end else if (c_last) begin
            c_d = '0;
            r_d = rp1;
          end else begin
            c_d = cp1;
          end
        end else begin
          case (pass_q)
            ccl_pkg::PASS_FWD: begin
              pass_d = ccl_pkg::PASS_BWD;
              r_d = RW'(nrows_i - NRW'(1));
              c_d = CW'(ncols_i - NCW'(1));
            end
            ccl_pkg::PASS_BWD: begin
              count_d = '0;
              i_d = LW'(1);
              pass_d = ccl_pkg::PASS_FIN;
              r_d = '0;
              c_d = '0;
            end
            default: ;
          endcase
        end
      end
      ccl_pkg::ST_FL_RD: eq_ra = i_q;
      ccl_pkg::ST_FL_WT: begin
        eq_ra = eq_rd;
        if (eq_rd == i_q) begin
          count_d = count_q + 1'b1;
          eq_we = 1'b1;
          eq_wa = i_q;
          eq_wd = count_q + 1'b1;
          i_d = i_q + 1'b1;
        end
      end
      ccl_pkg::ST_FL_RD2: begin
        eq_we = 1'b1;
        eq_wa = i_q;
        eq_wd = eq_rd;
        i_d = i_q + 1'b1;
      end
      ccl_pkg::ST_Z_EQD: begin
        img_we = 1'b1;
        img_wd = eq_rd;
        lab_d = eq_rd;
        pr_ra = eq_rd;
      end
      ccl_pkg::ST_Z_PRD: begin
        pr_we = 1'b1;
        pr_wa = lab_q;
        pr_wd = pr_upd;
      end
      ccl_pkg::ST_DONE: begin
        out_vld_d = 1'b1;
        out_d = '0;
        out_d.status = ovf_q ? ccl_pkg::STAT_OVF : ccl_pkg::STAT_OK;
        out_d.label_or_count = 10'(count_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ccl_pkg::ST_IDLE;
      pass_q       <= ccl_pkg::PASS_FWD;
      next_label_q <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_q       <= pass_d;
      next_label_q <= next_label_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    c_q     <= c_d;
    k_q     <= k_d;
    cur_q   <= cur_d;
    lab_q   <= lab_d;
    i_q     <= i_d;
    inb_q   <= inb_d;
    nb_q    <= nb_d;
    req_q   <= req_d;
    rd_ok_q <= rd_ok_d;
    out_q   <= out_d;
  end

  assign res_vld_o = out_vld_q;
  assign res_o     = out_q;

  a_label_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(next_label_q) < LABEL_DEPTH)
    else $error("provisional label beyond table");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_vld_i && cmd_rdy_o && (cmd_i.req == ccl_pkg::REQ_RDL || cmd_i.req == ccl_pkg::REQ_RDP))
    |=> (state_q == ccl_pkg::ST_RD_WAIT) ##1 res_vld_o)
    else $error("read result missing");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccl_pkg::ST_DONE) |-> (count_q <= next_label_q))
    else $error("more components than provisional labels");

endmodule

// ===== src/connected_component_labeler.sv =====
// 8-connected component labeler for a binary image of up to MAX_ROWS x MAX_COLS.
// Input beats carry a request kind in s_axis_tuser and its operands in
// s_axis_tdata: load a pixel, run the labeling, read a pixel label, or read one
// component's pixel count and bounding box. Every request returns exactly one
// result beat on the master side.
// Loads can be accepted every cycle while their result beats are taken at once;
// label and property reads pass through a wait state for the registered memory
// read before their result is issued and a new request can be taken.
// A run first clears the property memory, then makes three raster scans of the
// image (forward, backward, final), each pixel read through the single read port
// of the image memory; a foreground pixel in the first two scans also reads its
// four neighbours, and the label table is flattened before the last scan.
// The image size registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must change them only while the block is idle; it is not enforced.
// Reset returns the block to idle with no result pending and the image size at
// its maximum; image and table memories keep their contents.
// A result beat waits in the output register while m_axis_tready is low; the
// next request is accepted in the cycle the waiting beat is taken.
module connected_component_labeler #(
  parameter int MAX_ROWS    = ccl_pkg::MaxRowsDef,
  parameter int MAX_COLS    = ccl_pkg::MaxColsDef,
  parameter int LABEL_DEPTH = ccl_pkg::LabelDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row, col, pixel_value, component
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // status, label_or_count, num_pixels,
                                      // min_row, min_col, max_row, max_col
);

  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);

  logic [NRW-1:0] nrows_q;
  logic [NCW-1:0] ncols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrows_q <= NRW'(MAX_ROWS);
      ncols_q <= NCW'(MAX_COLS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ccl_pkg::REG_NUM_ROWS) begin
        if (cfg_data_i == 7'd0) nrows_q <= NRW'(1);
        else if (32'(cfg_data_i) > MAX_ROWS) nrows_q <= NRW'(MAX_ROWS);
        else nrows_q <= NRW'(cfg_data_i);
      end else begin
        if (cfg_data_i == 7'd0) ncols_q <= NCW'(1);
        else if (32'(cfg_data_i) > MAX_COLS) ncols_q <= NCW'(MAX_COLS);
        else ncols_q <= NCW'(cfg_data_i);
      end
    end
  end

  ccl_pkg::cmd_t cmd;
  ccl_pkg::res_t res;

  assign cmd.req  = s_axis_tuser;
  assign cmd.row  = s_axis_tdata[6:0];
  assign cmd.col  = s_axis_tdata[13:7];
  assign cmd.pix  = s_axis_tdata[21:14];
  assign cmd.comp = s_axis_tdata[31:22];

  ccl_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .LABEL_DEPTH(LABEL_DEPTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .nrows_i(nrows_q),
    .ncols_i(ncols_q),
    .cmd_vld_i(s_axis_tvalid),
    .cmd_rdy_o(s_axis_tready),
    .cmd_i(cmd),
    .res_vld_o(m_axis_tvalid),
    .res_rdy_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {3'b000, res.max_col, res.max_row, res.min_col, res.min_row,
                         res.num_pixels, res.label_or_count, res.status};

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rows  = ccl_pkg::MaxRowsDef;
  localparam int Cols  = ccl_pkg::MaxColsDef;
  localparam int Depth = ccl_pkg::LabelDepthDef;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  connected_component_labeler dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the labeler state.
  int unsigned pix_mem [Rows*Cols];
  bit          loaded  [Rows*Cols];
  int unsigned equiv   [Depth];
  int unsigned p_cnt [Depth], p_rmin [Depth], p_cmin [Depth], p_rmax [Depth], p_cmax [Depth];
  int unsigned label_hi, comp_total, img_rows, img_cols;
  bit          label_ovf;
  bit          idling = 1'b1;
  int          n_errors = 0;
  ccl_pkg::res_t expected_q [$];

  function automatic int unsigned pix_at(int r, int c);
    if (r < 0 || c < 0 || r >= img_rows || c >= img_cols) return 0;
    return pix_mem[r*Cols + c];
  endfunction

  function automatic void pix_put(int r, int c, int unsigned v);
    if (r < 0 || c < 0 || r >= img_rows || c >= img_cols) return;
    pix_mem[r*Cols + c] = v;
  endfunction

  function automatic int unsigned eq_rd(int unsigned x);
    return x < Depth ? equiv[x] : 0;
  endfunction

  function automatic void eq_wr(int unsigned x, int unsigned v);
    if (x < Depth) equiv[x] = v;
  endfunction

  function automatic void label_image();
    int unsigned nb [4];
    int unsigned best, cur, dense, lab, rr, cc;
    bit differs;
    label_hi = 0;
    label_ovf = 1'b0;
    // Forward scan against the upper-left neighbors.
    for (int r = 0; r < img_rows; r++) begin
      for (int c = 0; c < img_cols; c++) begin
        if (pix_at(r, c) == 0) continue;
        nb[0] = pix_at(r-1, c-1); nb[1] = pix_at(r-1, c);
        nb[2] = pix_at(r-1, c+1); nb[3] = pix_at(r, c-1);
        best = 0;
        for (int k = 0; k < 4; k++)
          if (nb[k] != 0 && (best == 0 || nb[k] < best)) best = nb[k];
        if (best != 0) begin
          pix_put(r, c, best);
          for (int k = 0; k < 4; k++) if (nb[k] > best) eq_wr(nb[k], best);
        end else if (label_hi >= Depth - 1) begin
          label_ovf = 1'b1;
          pix_put(r, c, 0);
        end else begin
          label_hi++;
          pix_put(r, c, label_hi);
          eq_wr(label_hi, label_hi);
        end
      end
    end
    // Backward scan against the lower-right neighbors.
    for (int r = img_rows - 1; r >= 0; r--) begin
      for (int c = img_cols - 1; c >= 0; c--) begin
        cur = pix_at(r, c);
        if (cur == 0) continue;
        nb[0] = pix_at(r, c+1); nb[1] = pix_at(r+1, c);
        nb[2] = pix_at(r+1, c+1); nb[3] = pix_at(r+1, c-1);
        best = cur;
        differs = 1'b0;
        for (int k = 0; k < 4; k++)
          if (nb[k] != 0 && nb[k] != cur) begin
            if (nb[k] < best) best = nb[k];
            differs = 1'b1;
          end
        if (differs && cur > best) begin
          eq_wr(cur, best);
          cur = best;
        end
        pix_put(r, c, eq_rd(cur));
      end
    end
    dense = 0;
    for (int unsigned i = 1; i <= label_hi; i++) begin
      if (eq_rd(i) != i) eq_wr(i, eq_rd(eq_rd(i)));
      else begin
        dense++;
        eq_wr(i, dense);
      end
    end
    comp_total = dense;
    for (int i = 0; i < Depth; i++) begin
      p_cnt[i] = 0; p_rmin[i] = 0; p_cmin[i] = 0; p_rmax[i] = 0; p_cmax[i] = 0;
    end
    for (int r = 0; r < img_rows; r++) begin
      for (int c = 0; c < img_cols; c++) begin
        lab = pix_at(r, c);
        if (lab == 0) continue;
        lab = eq_rd(lab);
        pix_put(r, c, lab);
        if (lab == 0 || lab >= Depth) continue;
        rr = r + 1;
        cc = c + 1;
        if (p_cnt[lab] == 0) begin
          p_rmin[lab] = rr; p_rmax[lab] = rr; p_cmin[lab] = cc; p_cmax[lab] = cc;
        end else begin
          if (rr < p_rmin[lab]) p_rmin[lab] = rr;
          if (rr > p_rmax[lab]) p_rmax[lab] = rr;
          if (cc < p_cmin[lab]) p_cmin[lab] = cc;
          if (cc > p_cmax[lab]) p_cmax[lab] = cc;
        end
        p_cnt[lab]++;
      end
    end
  endfunction

  function automatic ccl_pkg::res_t predict_result(logic [1:0] kind, int r, int c, int pv,
                                                   int cm);
    ccl_pkg::res_t res;
    bit in_img;
    res = '0;
    in_img = r >= 1 && c >= 1 && r <= img_rows && c <= img_cols;
    case (kind)
      ccl_pkg::REQ_LOAD: begin
        if (in_img) begin
          pix_put(r-1, c-1, (pv != 0) ? 1 : 0);
          loaded[(r-1)*Cols + c-1] = 1'b1;
        end else res.status = ccl_pkg::STAT_IDX;
      end
      ccl_pkg::REQ_RUN: begin
        label_image();
        res.status = label_ovf ? ccl_pkg::STAT_OVF : ccl_pkg::STAT_OK;
        res.label_or_count = comp_total[9:0];
      end
      ccl_pkg::REQ_RDL: begin
        if (in_img) res.label_or_count = 10'(pix_at(r-1, c-1));
        else res.status = ccl_pkg::STAT_IDX;
      end
      default: begin
        if (cm == 0 || cm > comp_total || cm >= Depth) res.status = ccl_pkg::STAT_IDX;
        else begin
          res.num_pixels = 13'(p_cnt[cm]);
          res.min_row = 7'(p_rmin[cm]);
          res.min_col = 7'(p_cmin[cm]);
          res.max_row = 7'(p_rmax[cm]);
          res.max_col = 7'(p_cmax[cm]);
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_req(logic [1:0] kind, int r, int c, int pv, int cm);
    ccl_pkg::res_t exp_res;
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {cm[9:0], pv[7:0], c[6:0], r[6:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = predict_result(kind, r, c, pv, cm);
    expected_q.insert(expected_q.size(), exp_res);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic idx, int v);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[6:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (v < 1) v = 1;
    if (idx == ccl_pkg::REG_NUM_ROWS) img_rows = v > Rows ? Rows : v;
    else img_cols = v > Cols ? Cols : v;
  endtask

  // Loads every pixel of the image in use that has never been written, so that
  // a run never touches undefined memory.
  task automatic fill_unloaded(int density);
    for (int r = 0; r < img_rows; r++)
      for (int c = 0; c < img_cols; c++)
        if (!loaded[r*Cols + c])
          send_req(ccl_pkg::REQ_LOAD, r+1, c+1,
                   ($urandom_range(0, 99) < density) ? $urandom_range(1, 255) : 0, 0);
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    ccl_pkg::res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding");
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, m_axis_tdata[1:0]);
        check_field("label_or_count", want.label_or_count, m_axis_tdata[11:2]);
        check_field("num_pixels", want.num_pixels, m_axis_tdata[24:12]);
        check_field("min_row", want.min_row, m_axis_tdata[31:25]);
        check_field("min_col", want.min_col, m_axis_tdata[38:32]);
        check_field("max_row", want.max_row, m_axis_tdata[45:39]);
        check_field("max_col", want.max_col, m_axis_tdata[52:46]);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    write_size(ccl_pkg::REG_NUM_ROWS, 4);
    write_size(ccl_pkg::REG_NUM_COLS, 5);
    fill_unloaded(0);
    send_req(ccl_pkg::REQ_LOAD, 1, 1, 255, 1023);
    send_req(ccl_pkg::REQ_LOAD, 2, 2, 1, 0);
    send_req(ccl_pkg::REQ_LOAD, 1, 5, 128, 0);
    send_req(ccl_pkg::REQ_LOAD, 4, 5, 7, 0);
    send_req(ccl_pkg::REQ_LOAD, 3, 4, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 1, 1, 0, 0);
    send_req(ccl_pkg::REQ_LOAD, 0, 3, 9, 0);
    send_req(ccl_pkg::REQ_LOAD, 5, 1, 9, 0);
    send_req(ccl_pkg::REQ_LOAD, 127, 127, 255, 0);
    send_req(ccl_pkg::REQ_RUN, 0, 0, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 1, 1, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 1, 5, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 4, 5, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 3, 4, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 0, 0, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 2, 6, 0, 0);
    for (int k = 0; k <= 4; k++) send_req(ccl_pkg::REQ_RDP, 0, 0, 0, k);
    send_req(ccl_pkg::REQ_RDP, 0, 0, 0, 1023);
  endtask

  task automatic test_size_clamp();
    write_size(ccl_pkg::REG_NUM_ROWS, 0);
    write_size(ccl_pkg::REG_NUM_COLS, 127);
    fill_unloaded(60);
    send_req(ccl_pkg::REQ_RUN, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send_req(ccl_pkg::REQ_RDP, 0, 0, 0, k);
    send_req(ccl_pkg::REQ_RDL, 1, 64, 0, 0);
    send_req(ccl_pkg::REQ_RDL, 2, 1, 0, 0);
    write_size(ccl_pkg::REG_NUM_ROWS, 64);
    write_size(ccl_pkg::REG_NUM_COLS, 1);
    fill_unloaded(60);
    send_req(ccl_pkg::REQ_RUN, 0, 0, 0, 0);
    send_req(ccl_pkg::REQ_RDP, 0, 0, 0, 1);
    send_req(ccl_pkg::REQ_RDL, 64, 1, 0, 0);
  endtask

  task automatic random_phase(int n_items);
    int pick, r, c;
    write_size(ccl_pkg::REG_NUM_ROWS, $urandom_range(0, 7) == 0 ? 64 : $urandom_range(1, 12));
    write_size(ccl_pkg::REG_NUM_COLS, $urandom_range(0, 7) == 0 ? 64 : $urandom_range(1, 12));
    fill_unloaded($urandom_range(20, 80));
    send_req(ccl_pkg::REQ_RUN, 0, 0, 0, 0);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 127);
        c = $urandom_range(0, 127);
      end else begin
        r = $urandom_range(1, img_rows);
        c = $urandom_range(1, img_cols);
      end
      // Reads inside the image only touch pixels that were loaded already.
      if (r >= 1 && c >= 1 && r <= img_rows && c <= img_cols && !loaded[(r-1)*Cols + c-1])
        r = 0;
      if (pick < 35)
        send_req(ccl_pkg::REQ_LOAD, r, c, $urandom_range(0, 1) ? $urandom_range(0, 255) : 0,
                 $urandom_range(0, 1023));
      else if (pick < 40)
        send_req(ccl_pkg::REQ_RUN, r, c, $urandom_range(0, 255), $urandom_range(0, 1023));
      else if (pick < 70)
        send_req(ccl_pkg::REQ_RDL, r, c, $urandom_range(0, 255), $urandom_range(0, 1023));
      else
        send_req(ccl_pkg::REQ_RDP, r, c, $urandom_range(0, 255),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                           : $urandom_range(0, comp_total + 1));
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) random_phase(70);
  endtask

  task automatic test_no_idle();
    idling = 1'b0;
    random_phase(80);
  endtask

  initial begin
    img_rows = Rows;
    img_cols = Cols;
    label_hi = 0;
    comp_total = 0;
    label_ovf = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      equiv[i] = 0;
      p_cnt[i] = 0; p_rmin[i] = 0; p_cmin[i] = 0; p_rmax[i] = 0; p_cmax[i] = 0;
    end
    for (int i = 0; i < Rows*Cols; i++) begin
      pix_mem[i] = 0;
      loaded[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_size_clamp();
    test_random();
    test_no_idle();
    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
